// File: sv/shfr_pkg.sv
package shfr_pkg;

    // Framing bytes
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ABORT_BYTE = 8'h7F;
    localparam logic [7:0] ESC_XOR    = 8'h20;

    // Input kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // One sample frames into at most five bytes: two escaped data bytes and a flag
    localparam int FRAME_MAX = 5;
    localparam int LEN_W     = 3;
    localparam int CMP_W     = 14;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] data;
        logic [LEN_W-1:0]          len;
    } frame_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        frame_t     frame;
    } ring_req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       overflow;
    } ring_rsp_t;

    typedef struct packed {
        logic             duty_valid;
        logic [CMP_W-1:0] pwm_compare;
        logic             byte_valid;
        logic [7:0]       tx_byte;
        logic             overflow;
    } result_t;

    function automatic logic needs_escape(input logic [7:0] b);
        needs_escape = (b == ESC_BYTE) || (b == FLAG_BYTE) || (b == ABORT_BYTE);
    endfunction

endpackage

// File: sv/shfr_if.sv
interface shfr_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink (input valid, input kind, input sample, output ready);
endinterface

interface shfr_out_if;
    logic        valid;
    logic        ready;
    logic        duty_valid;
    logic [13:0] pwm_compare;
    logic        byte_valid;
    logic [7:0]  tx_byte;
    logic        overflow;

    modport source (output valid, output duty_valid, output pwm_compare, output byte_valid,
                    output tx_byte, output overflow, input ready);
    modport sink (input valid, input duty_valid, input pwm_compare, input byte_valid,
                  input tx_byte, input overflow, output ready);
endinterface

// File: sv/shfr_frame_builder.sv
module shfr_frame_builder (
    input  logic [15:0]     sample,
    output shfr_pkg::frame_t frame
);

    logic [7:0]               hi_byte;
    logic [7:0]               lo_byte;
    logic                     hi_esc;
    logic                     lo_esc;
    logic [shfr_pkg::LEN_W-1:0] lo_pos;

    assign hi_byte = sample[15:8];
    assign lo_byte = sample[7:0];
    assign hi_esc  = shfr_pkg::needs_escape(hi_byte);
    assign lo_esc  = shfr_pkg::needs_escape(lo_byte);
    assign lo_pos  = hi_esc ? shfr_pkg::LEN_W'(2) : shfr_pkg::LEN_W'(1);

    // Place high byte, low byte and closing flag, escaping data bytes as needed
    always_comb
    begin
        frame.data = '0;
        frame.len  = lo_pos + (lo_esc ? shfr_pkg::LEN_W'(3) : shfr_pkg::LEN_W'(2));
        if (hi_esc)
        begin
            frame.data[0] = shfr_pkg::ESC_BYTE;
            frame.data[1] = hi_byte ^ shfr_pkg::ESC_XOR;
        end
        else
        begin
            frame.data[0] = hi_byte;
        end
        if (lo_esc)
        begin
            frame.data[lo_pos]                          = shfr_pkg::ESC_BYTE;
            frame.data[lo_pos + shfr_pkg::LEN_W'(1)]    = lo_byte ^ shfr_pkg::ESC_XOR;
        end
        else
        begin
            frame.data[lo_pos] = lo_byte;
        end
        frame.data[frame.len - shfr_pkg::LEN_W'(1)] = shfr_pkg::FLAG_BYTE;
    end

endmodule

// File: sv/shfr_tx_ring.sv
module shfr_tx_ring #(
    parameter int RING_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  shfr_pkg::ring_req_t req,
    output shfr_pkg::ring_rsp_t rsp
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int LEN_W  = shfr_pkg::LEN_W;

    // Frame records behind the head stage and the prefetch stage
    shfr_pkg::frame_t ring_mem [RING_DEPTH];

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  mem_cnt_reg, mem_cnt_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               head_valid_reg, head_valid_next;
    logic [LEN_W-1:0]   head_off_reg, head_off_next;
    shfr_pkg::frame_t   head_frame_reg, head_frame_next;
    logic               s1_valid_reg, s1_valid_next;
    shfr_pkg::frame_t   s1_frame_reg;

    logic [FILL_W-1:0]  space;
    logic [LEN_W-1:0]   keep_len;
    shfr_pkg::frame_t   entry;
    logic               push_keep;
    logic               head_done;
    logic               mem_we;
    logic               s1_load_new;
    logic               s1_load_mem;

    // Keep only the bytes that fit; once full, the rest of the frame drops
    assign space    = FILL_W'(RING_DEPTH) - fill_reg;
    assign keep_len = (space >= FILL_W'(req.frame.len)) ? req.frame.len : space[LEN_W-1:0];

    always_comb
    begin
        entry     = req.frame;
        entry.len = keep_len;
    end

    assign push_keep = req.push && (keep_len != '0);
    assign head_done = req.pop && head_valid_reg
                       && ((head_off_reg + LEN_W'(1)) == head_frame_reg.len);

    assign rsp.tx_byte  = head_valid_reg ? head_frame_reg.data[head_off_reg]
                                         : shfr_pkg::FLAG_BYTE;
    assign rsp.overflow = req.push && (keep_len != req.frame.len);

    // Advance the head, the prefetch stage and the record memory
    always_comb
    begin
        fill_next       = fill_reg;
        mem_cnt_next    = mem_cnt_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        head_valid_next = head_valid_reg;
        head_off_next   = head_off_reg;
        head_frame_next = head_frame_reg;
        s1_valid_next   = s1_valid_reg;
        mem_we          = 1'b0;
        s1_load_new     = 1'b0;
        s1_load_mem     = 1'b0;

        if (push_keep)
        begin
            fill_next = fill_reg + FILL_W'(keep_len);
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_off_next   = '0;
                head_frame_next = entry;
            end
            else if (!s1_valid_reg)
            begin
                s1_valid_next = 1'b1;
                s1_load_new   = 1'b1;
            end
            else
            begin
                mem_we       = 1'b1;
                mem_cnt_next = mem_cnt_reg + FILL_W'(1);
                wr_idx_next  = (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                     : wr_idx_reg + IDX_W'(1);
            end
        end

        if (req.pop && head_valid_reg)
        begin
            fill_next = fill_reg - FILL_W'(1);
            if (head_done)
            begin
                head_valid_next = s1_valid_reg;
                head_off_next   = '0;
                head_frame_next = s1_frame_reg;
                if (mem_cnt_reg != '0)
                begin
                    s1_load_mem  = 1'b1;
                    mem_cnt_next = mem_cnt_reg - FILL_W'(1);
                    rd_idx_next  = (rd_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                         : rd_idx_reg + IDX_W'(1);
                end
                else
                begin
                    s1_valid_next = 1'b0;
                end
            end
            else
            begin
                head_off_next = head_off_reg + LEN_W'(1);
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            mem_cnt_reg    <= '0;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            head_valid_reg <= 1'b0;
            head_off_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            mem_cnt_reg    <= mem_cnt_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            head_valid_reg <= head_valid_next;
            head_off_reg   <= head_off_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // Write records and read the next one into the prefetch stage
    always_ff @(posedge clk)
    begin
        head_frame_reg <= head_frame_next;
        if (mem_we)
        begin
            ring_mem[wr_idx_reg] <= entry;
        end
        if (s1_load_mem)
        begin
            s1_frame_reg <= ring_mem[rd_idx_reg];
        end
        else if (s1_load_new)
        begin
            s1_frame_reg <= entry;
        end
    end

    a_head_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg == (fill_reg != '0))
        else $error("head stage disagrees with fill level");

    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> (mem_cnt_reg == '0))
        else $error("records in memory while prefetch stage is empty");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill level above ring depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.overflow |=> (fill_reg == FILL_W'(RING_DEPTH)))
        else $error("overflow without a full ring");

    a_offset_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg |-> (head_off_reg < head_frame_reg.len))
        else $error("head offset past record length");

endmodule

// File: sv/shfr_out_stage.sv
module shfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  shfr_pkg::result_t data,
    output logic              ready,
    shfr_out_if.source        result
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    shfr_pkg::result_t out_data_reg, out_data_next;
    shfr_pkg::result_t skid_data_reg, skid_data_next;
    logic              taken;

    assign ready = !skid_valid_reg;
    assign taken = out_valid_reg && result.ready;

    // Refill the output register from the skid stage first, park requests that meet a stall
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || taken)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
                out_data_next  = data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.duty_valid  = out_data_reg.duty_valid;
    assign result.pwm_compare = out_data_reg.pwm_compare;
    assign result.byte_valid  = out_data_reg.byte_valid;
    assign result.tx_byte     = out_data_reg.tx_byte;
    assign result.overflow    = out_data_reg.overflow;

endmodule

// File: sv/sample_hdlc_framer_with_tx_ring.sv
// Sample framer with transmit ring. Each request on the item channel is either a 16-bit
// converter sample (kind 0) or a transmitter-ready tick (kind 1), and each produces exactly
// one registered result: a sample returns the PWM compare value sample >> 2 and queues
// its high byte, low byte and a 0x7E flag, data bytes 0x7D/0x7E/0x7F escaped as 0x7D and
// the byte XOR 0x20; a tick returns the oldest queued byte, or 0x7E when nothing is queued.
// Bytes that do not fit in the RING_DEPTH-byte ring are dropped and overflow is raised for
// that sample. One request is taken every clock: framing and the ring update sit between the
// input handshake and the output register, which has a one-entry skid stage, so the item
// channel stalls only when both hold results. Queued bytes are kept as per-sample frame
// records: a head register and a prefetch register in front of a RING_DEPTH-entry memory
// with one write and one registered read per cycle. No clearing pass is needed after reset.
module sample_hdlc_framer_with_tx_ring #(
    parameter int RING_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    shfr_in_if.sink    item,
    shfr_out_if.source result
);

    logic                accept;
    logic                stage_ready;
    shfr_pkg::frame_t    frame;
    shfr_pkg::ring_req_t ring_req;
    shfr_pkg::ring_rsp_t ring_rsp;
    shfr_pkg::result_t   res;

    assign item.ready = stage_ready;
    assign accept     = item.valid && stage_ready;

    shfr_frame_builder u_frame_builder (
        .sample (item.sample),
        .frame  (frame)
    );

    // Route accepted requests to the ring
    assign ring_req.push  = accept && (item.kind == shfr_pkg::KIND_SAMPLE);
    assign ring_req.pop   = accept && (item.kind == shfr_pkg::KIND_TICK);
    assign ring_req.frame = frame;

    shfr_tx_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .rsp   (ring_rsp)
    );

    // Assemble the result for the accepted request
    always_comb
    begin
        res = '0;
        if (item.kind == shfr_pkg::KIND_SAMPLE)
        begin
            res.duty_valid  = 1'b1;
            res.pwm_compare = item.sample[15:2];
            res.overflow    = ring_rsp.overflow;
        end
        else
        begin
            res.byte_valid = 1'b1;
            res.tx_byte    = ring_rsp.tx_byte;
        end
    end

    shfr_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .data   (res),
        .ready  (stage_ready),
        .result (result)
    );

endmodule
